### sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// Integer set table package
// Shared sizes, request and status codes, and control types.
// ----------------------------------------------------------------------------
package ist_pkg;

	// Number of cells in the table.
	localparam int CAPACITY  = 64;
	// Width of a stored value.
	localparam int DATA_W    = 32;
	// Width of the request index field.
	localparam int IDX_W     = 6;
	// Width of the response count field.
	localparam int OUT_CNT_W = 7;
	// Internal entry counter, wide enough to hold CAPACITY itself.
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	// Width used for cell positions, so that both the count and the
	// request index compare without loss.
	localparam int POS_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_READ   = 2'd3
	} req_op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_APPLY
	} ctl_state_t;

	// Strobes broadcast from the controller to every cell.
	typedef struct packed {
		logic sample;  // capture compare results for a new request
		logic append;  // write the fill value into the first free cell
		logic remove;  // shift down every cell at or after the match
	} cell_ctl_t;

endpackage

### sv/ist_if.sv
// ----------------------------------------------------------------------------
// Integer set table channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface ist_req_if import ist_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [1:0]               req_type;
	logic signed [DATA_W-1:0] value;
	logic [IDX_W-1:0]         index;

	modport source (output valid, output req_type, output value, output index, input ready);
	modport sink   (input valid, input req_type, input value, input index, output ready);
endinterface

interface ist_rsp_if import ist_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic signed [DATA_W-1:0] data;
	logic [OUT_CNT_W-1:0]     count;
	logic                     is_empty;
	logic [1:0]               status;

	modport source (output valid, output found, output data, output count, output is_empty,
		output status, input ready);
	modport sink   (input valid, input found, input data, input count, input is_empty,
		input status, output ready);
endinterface

### sv/integer_set_table_core.sv
// ----------------------------------------------------------------------------
// Integer set table core
// Ordered set of distinct signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Each request is handled thus: in the cycle it is accepted every cell
// compares its entry with the request value (and its position with the read
// index) and registers the result; then, in the apply state, the controller
// applies the request across the row (append into the first free cell, or a
// one-place shift down of every cell at or after the matching entry) and loads
// the response register. The apply step waits only while an earlier response
// is still held, and ready returns the cycle after it, so the block takes no
// new request until the previous one is applied. A new request is accepted
// while the previous response is still waiting to be taken. No clearing pass
// follows reset: an entry is only ever read once written.
module integer_set_table_core import ist_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ist_req_if.sink   req,
	ist_rsp_if.source rsp
);

	cell_ctl_t                cell_ctl;
	logic signed [DATA_W-1:0] fill;
	logic [CNT_W-1:0]         count;

	// Match chain: element g tells cell g whether a cell to its left matched.
	logic                     match_chain [CAPACITY+1];
	// Entry chain: element g is the entry of cell g; the spare element feeds
	// the last cell, whose shifted-in value is never read.
	logic signed [DATA_W-1:0] entry_chain [CAPACITY+1];
	logic                     hit_vec     [CAPACITY];

	logic                     any_hit;
	logic signed [DATA_W-1:0] rd_data;

	assign match_chain[0]        = 1'b0;
	assign entry_chain[CAPACITY] = entry_chain[CAPACITY-1];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		ist_cell u_cell (
			.clk        (clk),
			.pos        (POS_W'(g)),
			.ctl        (cell_ctl),
			.key        (req.value),
			.index      (req.index),
			.count      (count),
			.fill       (fill),
			.next_entry (entry_chain[g+1]),
			.left_match (match_chain[g]),
			.thru_match (match_chain[g+1]),
			.hit        (hit_vec[g]),
			.entry      (entry_chain[g])
		);
	end

	// At most one cell holds the read position, and every other cell is
	// gated to zero, so an OR across the row selects the addressed entry.
	always_comb begin
		any_hit = 1'b0;
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			any_hit = any_hit | hit_vec[i];
			rd_data = rd_data | (hit_vec[i] ? entry_chain[i] : '0);
		end
	end

	ist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.any_match (match_chain[CAPACITY]),
		.any_hit   (any_hit),
		.rd_data   (rd_data),
		.cell_ctl  (cell_ctl),
		.fill      (fill),
		.count     (count)
	);

endmodule

### sv/ist_cell.sv
// ----------------------------------------------------------------------------
// Integer set table cell
// One table entry with its own comparator and a link to its right neighbor.
// ----------------------------------------------------------------------------
module ist_cell import ist_pkg::*; (
	input  logic                     clk,
	input  logic [POS_W-1:0]         pos,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] key,
	input  logic [IDX_W-1:0]         index,
	input  logic [CNT_W-1:0]         count,
	input  logic signed [DATA_W-1:0] fill,
	input  logic signed [DATA_W-1:0] next_entry,
	input  logic                     left_match,
	output logic                     thru_match,
	output logic                     hit,
	output logic signed [DATA_W-1:0] entry
);

	logic signed [DATA_W-1:0] entry_q;
	logic                     match_s1;
	logic                     hit_s1;
	logic                     in_use;

	assign in_use = pos < POS_W'(count);

	always_ff @(posedge clk) begin
		if (ctl.sample) begin
			match_s1 <= in_use && (entry_q == key);
			hit_s1   <= in_use && (pos == POS_W'(index));
		end
	end

	// Cells at or after the removed value take their neighbor's entry.
	always_ff @(posedge clk) begin
		if (ctl.remove && (left_match || match_s1)) begin
			entry_q <= next_entry;
		end else if (ctl.append && (pos == POS_W'(count))) begin
			entry_q <= fill;
		end
	end

	assign thru_match = left_match || match_s1;
	assign hit        = hit_s1;
	assign entry      = entry_q;

endmodule

### sv/ist_ctrl.sv
// ----------------------------------------------------------------------------
// Integer set table controller
// Request sequencing, entry count and registered response.
// ----------------------------------------------------------------------------
module ist_ctrl import ist_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	ist_req_if.sink                  req,
	ist_rsp_if.source                rsp,
	input  logic                     any_match,
	input  logic                     any_hit,
	input  logic signed [DATA_W-1:0] rd_data,
	output cell_ctl_t                cell_ctl,
	output logic signed [DATA_W-1:0] fill,
	output logic [CNT_W-1:0]         count
);

	ctl_state_t               state_q, state_d;
	req_op_t                  op_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic [CNT_W-1:0]         count_q, count_d;
	logic                     apply;
	logic                     full;

	logic                     rsp_valid_q;
	logic                     found_q, found_d;
	logic signed [DATA_W-1:0] data_q, data_d;
	logic [OUT_CNT_W-1:0]     count_out_q;
	logic                     empty_q;
	status_t                  status_q, status_d;

	assign full = (count_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req.ready      = 1'b0;
		apply          = 1'b0;
		cell_ctl       = '0;
		unique case (state_q)
			CTL_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					cell_ctl.sample = 1'b1;
					state_d         = CTL_APPLY;
				end
			end
			CTL_APPLY: begin
				if (!rsp_valid_q || rsp.ready) begin
					apply           = 1'b1;
					cell_ctl.append = (op_s1 == REQ_ADD) && !any_match && !full;
					cell_ctl.remove = (op_s1 == REQ_REMOVE) && any_match;
					state_d         = CTL_IDLE;
				end
			end
		endcase
	end

	// Response fields and the next count for the held request.
	always_comb begin
		found_d  = 1'b0;
		data_d   = '0;
		status_d = STAT_OK;
		count_d  = count_q;
		unique case (op_s1)
			REQ_ADD: begin
				found_d = any_match;
				if (!any_match && full) begin
					status_d = STAT_FULL;
				end else if (!any_match) begin
					count_d = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				found_d = any_match;
				if (any_match) begin
					count_d = count_q - CNT_W'(1);
				end
			end
			REQ_QUERY: begin
				found_d = any_match;
			end
			REQ_READ: begin
				data_d   = rd_data;
				status_d = any_hit ? STAT_OK : STAT_BAD_INDEX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			op_s1       <= REQ_ADD;
		end else begin
			if (cell_ctl.sample) begin
				op_s1 <= req_op_t'(req.req_type);
			end
			if (apply) begin
				count_q <= count_d;
			end
			if (apply) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cell_ctl.sample) begin
			value_s1 <= req.value;
		end
		if (apply) begin
			found_q     <= found_d;
			data_q      <= data_d;
			count_out_q <= OUT_CNT_W'(count_d);
			empty_q     <= (count_d == '0);
			status_q    <= status_d;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = found_q;
	assign rsp.data     = data_q;
	assign rsp.count    = count_out_q;
	assign rsp.is_empty = empty_q;
	assign rsp.status   = status_q;

	assign fill  = value_s1;
	assign count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.remove |-> (count_q != '0))
		else $error("remove issued on an empty table");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.append |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not advance the count");

	a_apply_response: assert property (@(posedge clk) disable iff (!arst_n)
		apply |=> (rsp_valid_q && (state_q == CTL_IDLE)))
		else $error("applied request produced no response");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer set table core testbench
// Drives add, remove, query and read requests with random bursts and gaps,
// stalls the response side on changing patterns, and checks each response
// against an ordered-set predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
	import ist_pkg::*;

	// One request as queued for the driver.
	typedef struct {
		req_op_t                  op;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
	} set_req_t;

	// One response as the block should present it.
	typedef struct {
		logic                     found;
		logic signed [DATA_W-1:0] data;
		logic [OUT_CNT_W-1:0]     count;
		logic                     is_empty;
		status_t                  status;
	} set_rsp_t;

	logic clk;
	logic arst_n;

	ist_req_if req_ch ();
	ist_rsp_if rsp_ch ();

	integer_set_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Requests waiting for the driver, and responses the block still owes us.
	set_req_t request_backlog[$];
	set_rsp_t awaited_results[$];

	// The bench's own copy of the set, in insertion order.
	logic signed [DATA_W-1:0] set_entries[$];

	// Values used by the generator to steer requests toward hits.
	logic signed [DATA_W-1:0] value_pool[$];
	logic signed [DATA_W-1:0] added_values[$];

	// Driver and receiver pacing.
	int   burst_left;
	int   gap_left;
	logic req_taken;
	int   stall_mode;
	int   stall_cycle;

	// Run bookkeeping.
	int fail_cnt;
	int op_seen[4];
	int hit_cnt;
	int full_drops;
	int bad_reads;
	int peak_count;

	set_req_t next_req;
	set_req_t seen_req;
	set_rsp_t want;

	// Clock: 20 ns period.
	initial begin
		clk = 1'b0;
	end
	always #10 clk = ~clk;

	// Applies one request to the bench copy of the set and returns the
	// response the block must give for it.
	function automatic set_rsp_t set_apply(set_req_t r);
		set_rsp_t res;
		int       pos;
		pos = -1;
		res.found    = 1'b0;
		res.data     = '0;
		res.status   = STAT_OK;
		if (r.op != REQ_READ) begin
			foreach (set_entries[i]) begin
				if (pos < 0 && set_entries[i] == r.value)
					pos = i;
			end
		end
		case (r.op)
			REQ_ADD: begin
				if (pos >= 0) begin
					res.found = 1'b1;
				end else if (set_entries.size() >= CAPACITY) begin
					res.status = STAT_FULL;
					full_drops++;
				end else begin
					set_entries.insert(set_entries.size(), r.value);
				end
			end
			REQ_REMOVE: begin
				// Later entries move one place down, keeping their order.
				if (pos >= 0) begin
					res.found = 1'b1;
					set_entries.delete(pos);
				end
			end
			REQ_QUERY: begin
				res.found = (pos >= 0);
			end
			default: begin
				if (int'(r.index) < set_entries.size()) begin
					res.data = set_entries[r.index];
				end else begin
					res.status = STAT_BAD_INDEX;
					bad_reads++;
				end
			end
		endcase
		if (res.found)
			hit_cnt++;
		op_seen[r.op]++;
		if (set_entries.size() > peak_count)
			peak_count = set_entries.size();
		res.count    = OUT_CNT_W'(set_entries.size());
		res.is_empty = (set_entries.size() == 0);
		return res;
	endfunction

	task automatic queue_req(req_op_t op, logic signed [DATA_W-1:0] value,
		logic [IDX_W-1:0] index);
		set_req_t r;
		r.op    = op;
		r.value = value;
		r.index = index;
		request_backlog.insert(request_backlog.size(), r);
	endtask

	// Random requests. The run cycles through a growing phase that pushes
	// the table to full, a mixed phase, and a shrinking phase that drains it.
	// Removes and queries mostly pick values that were added earlier so that
	// they usually hit; adds mix fresh values with repeats.
	task automatic queue_random(int n);
		int                       phase;
		int                       roll;
		int                       pick;
		req_op_t                  op;
		logic signed [DATA_W-1:0] v;
		logic [IDX_W-1:0]         idx;
		for (int k = 0; k < n; k++) begin
			phase = (k / 150) % 3;
			roll  = $urandom_range(0, 99);
			case (phase)
				0:       op = (roll < 65) ? REQ_ADD : (roll < 70) ? REQ_REMOVE :
					(roll < 85) ? REQ_QUERY : REQ_READ;
				1:       op = (roll < 30) ? REQ_ADD : (roll < 60) ? REQ_REMOVE :
					(roll < 80) ? REQ_QUERY : REQ_READ;
				default: op = (roll < 10) ? REQ_ADD : (roll < 70) ? REQ_REMOVE :
					(roll < 85) ? REQ_QUERY : REQ_READ;
			endcase
			v    = $urandom;
			roll = $urandom_range(0, 99);
			case (op)
				REQ_ADD: begin
					if (roll < 30)
						v = value_pool[$urandom_range(0, value_pool.size() - 1)];
					else if (roll < 50 && added_values.size() > 0)
						v = added_values[$urandom_range(0, added_values.size() - 1)];
					added_values.insert(added_values.size(), v);
				end
				REQ_REMOVE: begin
					if (roll < 80 && added_values.size() > 0) begin
						pick = $urandom_range(0, added_values.size() - 1);
						v    = added_values[pick];
						added_values.delete(pick);
					end else if (roll < 90) begin
						v = value_pool[$urandom_range(0, value_pool.size() - 1)];
					end
				end
				REQ_QUERY: begin
					if (roll < 60 && added_values.size() > 0)
						v = added_values[$urandom_range(0, added_values.size() - 1)];
					else if (roll < 80)
						v = value_pool[$urandom_range(0, value_pool.size() - 1)];
				end
				default: ;
			endcase
			// Reads cover the whole index range, with extra weight near the
			// front where entries usually exist.
			idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 63)) :
				IDX_W'($urandom_range(0, 15));
			queue_req(op, v, idx);
		end
	endtask

	// Request driver: changes inputs on the falling edge only, and only once
	// the current request has been taken or none is presented.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (gap_left > 0) begin
				req_ch.valid <= 1'b0;
				gap_left     <= gap_left - 1;
			end else if (request_backlog.size() > 0) begin
				next_req = request_backlog.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.req_type <= next_req.op;
				req_ch.value    <= next_req.value;
				req_ch.index    <= next_req.index;
				if (burst_left <= 1) begin
					// A third of the bursts run straight into the next one.
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response side stall pattern: the mode is redrawn by a free-running cycle
	// counter among always ready, mostly ready, rarely ready and alternating.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			if (stall_cycle % 64 == 63)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0:       rsp_ch.ready <= 1'b1;
				1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= stall_cycle[0];
			endcase
		end
	end

	// Monitor: checks a taken response first, then predicts the response of
	// a request taken on the same edge. A response can never belong to a
	// request taken on the same edge, so this order is safe.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0) begin
				$error("response with no request outstanding");
				fail_cnt++;
			end else begin
				want = awaited_results.pop_front();
				if (rsp_ch.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
					fail_cnt++;
				end
				if (rsp_ch.data !== want.data) begin
					$error("data: expected %0d, got %0d", want.data, rsp_ch.data);
					fail_cnt++;
				end
				if (rsp_ch.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, rsp_ch.count);
					fail_cnt++;
				end
				if (rsp_ch.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty,
						rsp_ch.is_empty);
					fail_cnt++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					fail_cnt++;
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			seen_req.op    = req_op_t'(req_ch.req_type);
			seen_req.value = req_ch.value;
			seen_req.index = req_ch.index;
			awaited_results.insert(awaited_results.size(), set_apply(seen_req));
		end
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
	end

	// Hard limit on the run time, far above the slowest legal run.
	initial begin
		#5ms;
		$display("integer_set_table_core regression: fail");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_ADD;
		req_ch.value    = '0;
		req_ch.index    = '0;
		rsp_ch.ready    = 1'b0;
		req_taken       = 1'b0;
		burst_left      = 1;
		gap_left        = 0;
		stall_mode      = 0;
		stall_cycle     = 0;
		fail_cnt        = 0;
		hit_cnt         = 0;
		full_drops      = 0;
		bad_reads       = 0;
		peak_count      = 0;
		foreach (op_seen[i])
			op_seen[i] = 0;

		// Value pool: the numeric extremes plus random words.
		value_pool.insert(value_pool.size(), 32'sh8000_0000);
		value_pool.insert(value_pool.size(), 32'sh7FFF_FFFF);
		value_pool.insert(value_pool.size(), 32'sh0000_0000);
		value_pool.insert(value_pool.size(), -32'sd1);
		for (int i = 0; i < 60; i++)
			value_pool.insert(value_pool.size(), $urandom);

		// Directed opening: every request on an empty table, the value
		// extremes, a repeated add, reads inside and past the count, removal
		// from the middle, the end and the front, and a drain back to empty.
		queue_req(REQ_READ,   '0,              6'd0);
		queue_req(REQ_QUERY,  '0,              6'd0);
		queue_req(REQ_REMOVE, 32'sd5,          6'd0);
		queue_req(REQ_ADD,    32'sh8000_0000,  6'd0);
		queue_req(REQ_ADD,    32'sh7FFF_FFFF,  6'd0);
		queue_req(REQ_ADD,    32'sh0000_0000,  6'd0);
		queue_req(REQ_ADD,    -32'sd1,         6'd0);
		queue_req(REQ_ADD,    32'sh7FFF_FFFF,  6'd0);
		queue_req(REQ_QUERY,  32'sh8000_0000,  6'd0);
		queue_req(REQ_QUERY,  32'sd1,          6'd0);
		queue_req(REQ_READ,   '0,              6'd0);
		queue_req(REQ_READ,   '0,              6'd3);
		queue_req(REQ_READ,   '0,              6'd4);
		queue_req(REQ_READ,   '0,              6'd63);
		queue_req(REQ_REMOVE, 32'sh0000_0000,  6'd0);
		queue_req(REQ_READ,   '0,              6'd2);
		queue_req(REQ_REMOVE, -32'sd1,         6'd0);
		queue_req(REQ_REMOVE, 32'sh8000_0000,  6'd0);
		queue_req(REQ_REMOVE, 32'sh7FFF_FFFF,  6'd0);
		queue_req(REQ_ADD,    32'sh5555_5555,  6'd0);
		queue_req(REQ_ADD,    32'shAAAA_AAAA,  6'd0);
		queue_req(REQ_READ,   '0,              6'd1);
		queue_req(REQ_REMOVE, 32'shAAAA_AAAA,  6'd0);
		queue_req(REQ_REMOVE, 32'sh5555_5555,  6'd0);

		queue_random(1200);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be taken and every response to arrive,
		// then keep the clock running so that any stray response would show.
		while (request_backlog.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Requests: %0d adds, %0d removes, %0d queries, %0d reads; %0d hits.",
			op_seen[REQ_ADD], op_seen[REQ_REMOVE], op_seen[REQ_QUERY],
			op_seen[REQ_READ], hit_cnt);
		$display("Peak fill %0d of %0d, %0d adds dropped on a full table, %0d %s",
			peak_count, CAPACITY, full_drops, bad_reads, "reads past the count.");
		if (fail_cnt == 0)
			$display("integer_set_table_core regression: pass");
		else
			$display("integer_set_table_core regression: fail");
		$finish;
	end

endmodule
